[src/kst_pkg.sv]
package kst_pkg;

    localparam int CAPACITY = 64;
    localparam int ID_BITS  = 16;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SUM_W  = 16 + IDX_W;
    localparam int SQ_W   = 32 + IDX_W;
    localparam int P2_W   = 2 * SUM_W;
    localparam int D_W    = CNT_W + SQ_W;
    localparam int NN_W   = 2 * CNT_W;
    localparam int DIV_W  = D_W + 16;
    localparam int ALU_W  = DIV_W + 1;
    localparam int SQ_TOP = ((DIV_W - 1) / 2) * 2;
    localparam int STEP_W = $clog2(DIV_W + 1);

    localparam logic [15:0] EMPTY_MIN = 16'hFFFF;

    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_DEL = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] record_id;
        logic [15:0] score_value;
    } t_cmd;

    typedef struct packed {
        logic        op_ok;
        logic [6:0]  entry_count;
        logic [15:0] min_score;
        logic [15:0] max_score;
        logic [23:0] mean_score;
        logic [23:0] std_dev;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEL_RD,
        S_DEL_CMP,
        S_SH_RD,
        S_SH_WR,
        S_MM_RD,
        S_MM_CMP,
        S_MUL,
        S_SETUP,
        S_DIV_M,
        S_DIV_D,
        S_SQRT
    } t_state;

endpackage

[src/kst_sub.sv]
module kst_sub (
    input  logic [kst_pkg::ALU_W-1:0] i_a,
    input  logic [kst_pkg::ALU_W-1:0] i_b,
    output logic [kst_pkg::ALU_W-1:0] o_diff,
    output logic                      o_ge
);
    import kst_pkg::*;

    logic [ALU_W:0] w_full;

    // The borrow out of one subtraction gives both the difference and the compare.
    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_full[ALU_W-1:0];
    assign o_ge   = ~w_full[ALU_W];
endmodule

[src/kst_table.sv]
module kst_table (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [kst_pkg::IDX_W-1:0] i_waddr,
    input  logic [kst_pkg::ID_BITS-1:0] i_wid,
    input  logic [15:0]               i_wscore,
    input  logic [kst_pkg::IDX_W-1:0] i_raddr,
    output logic [kst_pkg::ID_BITS-1:0] o_rid,
    output logic [15:0]               o_rscore
);
    import kst_pkg::*;

    logic [ID_BITS-1:0] r_ids    [CAPACITY];
    logic [15:0]        r_scores [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_ids[i_waddr]    <= i_wid;
            r_scores[i_waddr] <= i_wscore;
        end
        o_rid    <= r_ids[i_raddr];
        o_rscore <= r_scores[i_raddr];
    end
endmodule

[src/keyed_score_table_statistics.sv]
// Keyed score table with count, minimum, maximum, mean and standard deviation.
// Steps: id search and gap closing (deletes only), min/max scan, then the mean and
// variance divides on the shared divider and the square root if entries remain.
// Throughput: one transaction at a time; busy is high until o_done pulses.
// Reset (i_rst_n low, synchronous) empties the table; the receiver cannot stall.
module keyed_score_table_statistics (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  kst_pkg::t_cmd i_cmd,
    output logic          o_done,
    output kst_pkg::t_res o_res
);
    import kst_pkg::*;

    // Sequencer state.
    t_state r_state, n_state;

    // Latched transaction and running totals.
    t_cmd              r_cmd, n_cmd;
    logic              r_ok, n_ok;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [SQ_W-1:0]   r_sq, n_sq;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [15:0]       r_min, n_min;
    logic [15:0]       r_max, n_max;

    // Statistics datapath.
    logic [D_W-1:0]    r_p1, n_p1;
    logic [P2_W-1:0]   r_p2, n_p2;
    logic [NN_W-1:0]   r_nn, n_nn;
    logic [DIV_W-1:0]  r_num, n_num;
    logic [NN_W-1:0]   r_rem, n_rem;
    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [NN_W-1:0]   r_div, n_div;
    logic [23:0]       r_mean, n_mean;
    logic [DIV_W-1:0]  r_v, n_v;
    logic [ALU_W-1:0]  r_root, n_root;
    logic [ALU_W-1:0]  r_bit, n_bit;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_done, n_done;
    t_res              r_out, n_out;

    // Table ports.
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [ID_BITS-1:0] w_wid;
    logic [15:0]        w_wscore;
    logic [IDX_W-1:0]   w_raddr;
    logic [ID_BITS-1:0] w_rid;
    logic [15:0]        w_rscore;

    // Shared subtract and compare unit.
    logic [ALU_W-1:0]   w_alu_a, w_alu_b, w_alu_diff;
    logic               w_alu_ge;

    logic [CNT_W-1:0]   w_idx_inc;
    logic [NN_W:0]      w_trial;
    logic [D_W-1:0]     w_d;
    logic [DIV_W-1:0]   w_quo_next;
    logic [ID_BITS-1:0] w_cmd_id;
    logic [31:0]        w_sc_sq;
    logic [31:0]        w_old_sq;

    assign w_idx_inc  = r_idx + 1'b1;
    assign w_trial    = {r_rem, r_num[DIV_W-1]};
    assign w_d        = r_p1 - D_W'(r_p2);
    assign w_quo_next = {r_quo[DIV_W-2:0], w_alu_ge};
    assign w_cmd_id   = ID_BITS'(r_cmd.record_id);
    assign w_sc_sq    = 32'(i_cmd.score_value) * 32'(i_cmd.score_value);
    assign w_old_sq   = 32'(w_rscore) * 32'(w_rscore);

    kst_table u_table (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wid    (w_wid),
        .i_wscore (w_wscore),
        .i_raddr  (w_raddr),
        .o_rid    (w_rid),
        .o_rscore (w_rscore)
    );

    kst_sub u_sub (
        .i_a    (w_alu_a),
        .i_b    (w_alu_b),
        .o_diff (w_alu_diff),
        .o_ge   (w_alu_ge)
    );

    // The shared unit serves the restoring divider in both divide phases and the
    // square root in its own phase.
    always_comb begin
        if (r_state == S_SQRT) begin
            w_alu_a = ALU_W'(r_v);
            w_alu_b = r_root + r_bit;
        end else begin
            w_alu_a = ALU_W'(w_trial);
            w_alu_b = ALU_W'(r_div);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (i_cmd.func == FUNC_DEL) ? S_DEL_RD : S_MM_RD;
                end
            end
            S_DEL_RD:  n_state = (r_idx < r_count) ? S_DEL_CMP : S_MM_RD;
            S_DEL_CMP: n_state = (w_rid == w_cmd_id) ? S_SH_RD : S_DEL_RD;
            S_SH_RD:   n_state = (w_idx_inc < r_count) ? S_SH_WR : S_MM_RD;
            S_SH_WR:   n_state = S_SH_RD;
            S_MM_RD: begin
                if (r_idx < r_count) begin
                    n_state = S_MM_CMP;
                end else if (r_count == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MM_CMP:  n_state = S_MM_RD;
            S_MUL:     n_state = S_SETUP;
            S_SETUP:   n_state = S_DIV_M;
            S_DIV_M:   n_state = (r_step == STEP_W'(DIV_W - 1)) ? S_DIV_D : S_DIV_M;
            S_DIV_D:   n_state = (r_step == STEP_W'(DIV_W - 1)) ? S_SQRT : S_DIV_D;
            S_SQRT:    n_state = r_bit[0] ? S_IDLE : S_SQRT;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_cmd    = r_cmd;
        n_ok     = r_ok;
        n_count  = r_count;
        n_sum    = r_sum;
        n_sq     = r_sq;
        n_idx    = r_idx;
        n_min    = r_min;
        n_max    = r_max;
        n_p1     = r_p1;
        n_p2     = r_p2;
        n_nn     = r_nn;
        n_num    = r_num;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_div    = r_div;
        n_mean   = r_mean;
        n_v      = r_v;
        n_root   = r_root;
        n_bit    = r_bit;
        n_step   = r_step;
        n_done   = 1'b0;
        n_out    = r_out;
        w_we     = 1'b0;
        w_waddr  = r_idx[IDX_W-1:0];
        w_wid    = w_rid;
        w_wscore = w_rscore;
        w_raddr  = r_idx[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                n_min = EMPTY_MIN;
                n_max = '0;
                if (start) begin
                    n_cmd = i_cmd;
                    n_ok  = 1'b0;
                    if (i_cmd.func == FUNC_ADD && r_count < CNT_W'(CAPACITY)) begin
                        // Append at the end of the packed table.
                        w_we     = 1'b1;
                        w_waddr  = r_count[IDX_W-1:0];
                        w_wid    = ID_BITS'(i_cmd.record_id);
                        w_wscore = i_cmd.score_value;
                        n_count  = r_count + 1'b1;
                        n_sum    = r_sum + SUM_W'(i_cmd.score_value);
                        n_sq     = r_sq + SQ_W'(w_sc_sq);
                        n_ok     = 1'b1;
                    end
                end
            end
            S_DEL_RD: begin
                if (!(r_idx < r_count)) begin
                    n_idx = '0;
                end
            end
            S_DEL_CMP: begin
                if (w_rid == w_cmd_id) begin
                    n_ok  = 1'b1;
                    n_sum = r_sum - SUM_W'(w_rscore);
                    n_sq  = r_sq - SQ_W'(w_old_sq);
                end else begin
                    n_idx = w_idx_inc;
                end
            end
            S_SH_RD: begin
                w_raddr = w_idx_inc[IDX_W-1:0];
                if (!(w_idx_inc < r_count)) begin
                    n_count = r_count - 1'b1;
                    n_idx   = '0;
                end
            end
            S_SH_WR: begin
                // Move the next record down by one slot.
                w_we  = 1'b1;
                n_idx = w_idx_inc;
            end
            S_MM_RD: begin
                if (!(r_idx < r_count) && r_count == '0) begin
                    n_done           = 1'b1;
                    n_out.op_ok      = r_ok;
                    n_out.entry_count = 7'(r_count);
                    n_out.min_score  = r_min;
                    n_out.max_score  = r_max;
                    n_out.mean_score = '0;
                    n_out.std_dev    = '0;
                end
            end
            S_MM_CMP: begin
                if (w_rscore < r_min) begin
                    n_min = w_rscore;
                end
                if (w_rscore > r_max) begin
                    n_max = w_rscore;
                end
                n_idx = w_idx_inc;
            end
            S_MUL: begin
                n_p1 = D_W'(r_sq) * D_W'(r_count);
                n_p2 = P2_W'(r_sum) * P2_W'(r_sum);
                n_nn = NN_W'(r_count) * NN_W'(r_count);
            end
            S_SETUP: begin
                n_num  = DIV_W'({r_sum, 8'h00});
                n_div  = NN_W'(r_count);
                n_rem  = '0;
                n_quo  = '0;
                n_step = '0;
            end
            S_DIV_M, S_DIV_D: begin
                n_rem  = w_alu_ge ? w_alu_diff[NN_W-1:0] : w_trial[NN_W-1:0];
                n_quo  = w_quo_next;
                n_num  = {r_num[DIV_W-2:0], 1'b0};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    n_step = '0;
                    n_rem  = '0;
                    n_quo  = '0;
                    if (r_state == S_DIV_M) begin
                        // The variance numerator n*sum(s^2) - sum(s)^2 over n^2.
                        n_mean = w_quo_next[23:0];
                        n_num  = {w_d, 16'h0000};
                        n_div  = r_nn;
                    end else begin
                        n_v    = w_quo_next;
                        n_root = '0;
                        n_bit  = ALU_W'(1) << SQ_TOP;
                    end
                end
            end
            S_SQRT: begin
                if (w_alu_ge) begin
                    n_v    = w_alu_diff[DIV_W-1:0];
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_done            = 1'b1;
                    n_out.op_ok       = r_ok;
                    n_out.entry_count = 7'(r_count);
                    n_out.min_score   = r_min;
                    n_out.max_score   = r_max;
                    n_out.mean_score  = r_mean;
                    n_out.std_dev     = n_root[23:0];
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_sq    <= n_sq;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_ok   <= n_ok;
        r_idx  <= n_idx;
        r_min  <= n_min;
        r_max  <= n_max;
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_nn   <= n_nn;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_div  <= n_div;
        r_mean <= n_mean;
        r_v    <= n_v;
        r_root <= n_root;
        r_bit  <= n_bit;
        r_step <= n_step;
        r_out  <= n_out;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_out;
endmodule

[bench/keyed_score_table_statistics_tb.sv]
`timescale 1ns / 100ps

// Scoreboard for the keyed score table. It keeps its own copy of the table and
// works out the expected statistics for every command, refused or not.
class score_table_board;
    logic [15:0]   held_ids[$];
    logic [15:0]   held_scores[$];
    kst_pkg::t_res pending_stats[$];
    int            mismatches;
    int            results_seen;
    int            adds_refused;
    int            deletes_missed;
    int            peak_fill;

    function new();
        mismatches     = 0;
        results_seen   = 0;
        adds_refused   = 0;
        deletes_missed = 0;
        peak_fill      = 0;
    endfunction

    // Integer square root by the usual bit-pair method.
    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bit_pair;
        root     = 0;
        bit_pair = 64'd1 << 62;
        while (bit_pair > v) bit_pair = bit_pair >> 2;
        while (bit_pair != 0) begin
            if (v >= root + bit_pair) begin
                v    = v - (root + bit_pair);
                root = (root >> 1) + bit_pair;
            end else begin
                root = root >> 1;
            end
            bit_pair = bit_pair >> 2;
        end
        return root;
    endfunction

    // Applies one command to the table copy and returns the statistics after it.
    function kst_pkg::t_res apply_command(kst_pkg::t_cmd cmd);
        kst_pkg::t_res   stats;
        longint unsigned n, total, squares, nn, spread, whole, rest, q;
        int              hit;
        stats.op_ok = 1'b0;
        if (cmd.func == kst_pkg::FUNC_ADD) begin
            if (held_ids.size() < kst_pkg::CAPACITY) begin
                held_ids    = {held_ids, cmd.record_id};
                held_scores = {held_scores, cmd.score_value};
                stats.op_ok = 1'b1;
            end else begin
                adds_refused++;
            end
        end else begin
            hit = -1;
            foreach (held_ids[k]) begin
                if (hit < 0 && held_ids[k] == cmd.record_id) hit = k;
            end
            if (hit >= 0) begin
                held_ids.delete(hit);
                held_scores.delete(hit);
                stats.op_ok = 1'b1;
            end else begin
                deletes_missed++;
            end
        end
        if (held_ids.size() > peak_fill) peak_fill = held_ids.size();

        n       = held_scores.size();
        total   = 0;
        squares = 0;
        stats.min_score = kst_pkg::EMPTY_MIN;
        stats.max_score = 16'd0;
        foreach (held_scores[k]) begin
            total   += held_scores[k];
            squares += longint'(held_scores[k]) * held_scores[k];
            if (held_scores[k] < stats.min_score) stats.min_score = held_scores[k];
            if (held_scores[k] > stats.max_score) stats.max_score = held_scores[k];
        end
        stats.entry_count = n[6:0];
        stats.mean_score  = 24'd0;
        stats.std_dev     = 24'd0;
        if (n != 0) begin
            nn     = n * n;
            spread = n * squares - total * total;
            whole  = spread / nn;
            rest   = spread % nn;
            q      = (whole << 16) + ((rest << 16) / nn);
            stats.mean_score = 24'((total << 8) / n);
            stats.std_dev    = 24'(int_sqrt(q));
        end
        return stats;
    endfunction

    function void note_command(kst_pkg::t_cmd cmd);
        pending_stats = {pending_stats, apply_command(cmd)};
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    task check_result(kst_pkg::t_res got);
        kst_pkg::t_res want;
        if (pending_stats.size() == 0) begin
            report("pulse with nothing outstanding", 1, 0);
            return;
        end
        want = pending_stats.pop_front();
        if (got.op_ok       !== want.op_ok)       report("op_ok", got.op_ok, want.op_ok);
        if (got.entry_count !== want.entry_count)
            report("entry_count", got.entry_count, want.entry_count);
        if (got.min_score   !== want.min_score)
            report("min_score", got.min_score, want.min_score);
        if (got.max_score   !== want.max_score)
            report("max_score", got.max_score, want.max_score);
        if (got.mean_score  !== want.mean_score)
            report("mean_score", got.mean_score, want.mean_score);
        if (got.std_dev     !== want.std_dev)  report("std_dev", got.std_dev, want.std_dev);
        results_seen++;
    endtask
endclass

module testbench;
    import kst_pkg::*;

    // The limit allows for the slowest transaction plus the longest sender gap on
    // every item, so it sits well over the slowest correct run.
    localparam int RANDOM_ITEMS = 1880;
    localparam int CYCLE_LIMIT  = 5_000_000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_cmd i_cmd;
    logic o_done;
    t_res o_res;

    score_table_board board;
    int               cycle_count = 0;
    int               adds_sent;
    int               deletes_sent;

    keyed_score_table_statistics DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("keyed_score_table_statistics verification failed");
            $finish;
        end
    end

    // Results are only valid for the one cycle marked by o_done, and the block
    // cannot be held off, so every pulse is checked on the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) board.check_result(o_res);
    end

    // Mostly back-to-back requests, some short pauses and the odd long one, so
    // that idle spells land on every stage of the search, scan and arithmetic.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 400);
    endfunction

    // Presents one command, holds it until the block takes it, then idles.
    // Start is lowered only when a gap follows, so it is never dropped and
    // raised again within one time step.
    task automatic send_command(logic func, logic [15:0] id, logic [15:0] score);
        t_cmd cmd;
        int   gap;
        cmd.func        = func;
        cmd.record_id   = id;
        cmd.score_value = score;
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_command(cmd);
        if (func == FUNC_ADD) adds_sent++;
        else deletes_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Random score: the extremes and a few repeated values turn up often, so
    // equal scores (zero deviation) and the widest spreads both get exercised.
    function automatic logic [15:0] pick_score();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return 16'h0000;
        if (roll < 20) return 16'hFFFF;
        if (roll < 30) return 16'(1000 * $urandom_range(3));
        return 16'($urandom);
    endfunction

    // Identifiers come half of the time from a small pool so that duplicates are common,
    // with full-range values often enough that every id bit toggles.
    function automatic logic [15:0] pick_id();
        if ($urandom_range(1) == 0) return 16'($urandom_range(15));
        return 16'($urandom);
    endfunction

    initial begin
        int          add_bias;
        logic [15:0] id;
        board        = new();
        adds_sent    = 0;
        deletes_sent = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cmd        = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: a delete on the empty table, the field extremes,
        // duplicate ids where the oldest must go first, a delete that misses,
        // emptying the table again, and a pair of equal scores under one id.
        send_command(FUNC_DEL, 16'd5,     16'hFFFF);
        send_command(FUNC_ADD, 16'h0000,  16'h0000);
        send_command(FUNC_ADD, 16'hFFFF,  16'hFFFF);
        send_command(FUNC_ADD, 16'd7,     16'd1000);
        send_command(FUNC_ADD, 16'd7,     16'd2000);
        send_command(FUNC_DEL, 16'd7,     16'h0000);
        send_command(FUNC_DEL, 16'd7,     16'h0000);
        send_command(FUNC_DEL, 16'd7,     16'h0000);
        send_command(FUNC_DEL, 16'hFFFF,  16'h0000);
        send_command(FUNC_DEL, 16'h0000,  16'h0000);
        send_command(FUNC_DEL, 16'h0000,  16'h0000);
        send_command(FUNC_ADD, 16'hAAAA,  16'h5555);
        send_command(FUNC_ADD, 16'h5555,  16'hAAAA);
        send_command(FUNC_ADD, 16'd1,     16'hFFFF);
        send_command(FUNC_ADD, 16'd1,     16'hFFFF);
        send_command(FUNC_DEL, 16'hAAAA,  16'h0000);
        send_command(FUNC_DEL, 16'h5555,  16'h0000);
        send_command(FUNC_DEL, 16'd1,     16'h0000);
        send_command(FUNC_DEL, 16'd1,     16'h0000);

        // Random part in phases: filling phases drive the table to full and
        // then keep knocking on it, draining phases empty it, balanced phases
        // churn the middle. Most deletes name an id that is actually held.
        add_bias = 90;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                case ($urandom_range(2))
                    0: add_bias = 90;
                    1: add_bias = 50;
                    default: add_bias = 12;
                endcase
            end
            if ($urandom_range(99) < add_bias) begin
                send_command(FUNC_ADD, pick_id(), pick_score());
            end else begin
                if (board.held_ids.size() > 0 && $urandom_range(99) < 80)
                    id = board.held_ids[$urandom_range(board.held_ids.size() - 1)];
                else
                    id = pick_id();
                send_command(FUNC_DEL, id, pick_score());
            end
        end
        start <= 1'b0;

        // Drain: wait for every outstanding result, then keep the clock running longer
        // than the slowest transaction takes, so that any stray pulse would show up.
        while (board.pending_stats.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);

        $display("Ran %0d adds and %0d deletes; %0d results checked in %0d cycles.",
                 adds_sent, deletes_sent, board.results_seen, cycle_count);
        $display("Peak fill %0d of %0d, %0d adds refused on a full table, %0d deletes missed.",
                 board.peak_fill, CAPACITY, board.adds_refused, board.deletes_missed);
        if (board.mismatches == 0) begin
            $display("keyed_score_table_statistics verification clean");
        end else begin
            $display("keyed_score_table_statistics verification failed");
        end
        $finish;
    end
endmodule

[keyed_score_table_statistics.f]
src/kst_pkg.sv
src/kst_sub.sv
src/kst_table.sv
src/keyed_score_table_statistics.sv
bench/keyed_score_table_statistics_tb.sv
